// ===== src/phc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Printable character histogram package
// Shared sizes, command and result codes, and the result record.
// ----------------------------------------------------------------------------
package phc_pkg;

    localparam int BIN_COUNT    = 128;
    localparam int BIN_BITS     = $clog2(BIN_COUNT);
    localparam int COUNTER_BITS = 16;
    localparam int CHAR_W       = 7;
    localparam int BYTE_W       = 8;
    localparam int LEN_W        = 16;
    localparam int VALUE_W      = 16;
    localparam int CFG_IDX_W    = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_LOW_CHAR  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_CHAR = 1'b1;

    localparam logic [CHAR_W-1:0] LOW_CHAR_RST  = 7'd32;
    localparam logic [CHAR_W-1:0] HIGH_CHAR_RST = 7'd126;

    typedef logic [COUNTER_BITS-1:0] t_cnt;

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_DATA  = 2'd1,
        CMD_ABORT = 2'd2,
        CMD_READ  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_DONE    = 2'd0,
        KIND_ABORTED = 2'd1,
        KIND_READ    = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind               kind;
        logic [VALUE_W-1:0]  value;
    } t_result;

endpackage

// ===== src/phc_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module phc_ram #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/phc_out_reg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result output register
// Holds one result beat until the consumer takes it.
// ----------------------------------------------------------------------------
module phc_out_reg
    import phc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  t_result            i_res,
    output logic               o_free,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [1:0]         o_result_kind,
    output logic [VALUE_W-1:0] o_value
);

    logic    r_valid;
    t_result r_res;

    // The register can take a new beat when empty or when its beat leaves now.
    assign o_free = !r_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (i_load && o_free) begin
            r_res <= i_res;
        end
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    assign o_out_valid   = r_valid;
    assign o_result_kind = r_res.kind;
    assign o_value       = r_res.value;

endmodule

// ===== src/printable_char_histogram_top.sv =====
`timescale 1ns / 1ps
// An abort or a zero length start passes its result through S_EMIT to the output register;
// a read goes through S_READ first. A data beat that updates a bin passes through S_BUMP.
// A closing data beat walks all BIN_COUNT bins in S_WALK (after S_BUMP if it updates a bin),
// then its count goes through S_EMIT, and the next beat is taken once S_EMIT has handed it on.
// The block takes one item at a time; it stalls its input in every state but S_IDLE.
// Reset is synchronous, active low; bin valid flags clear at once, with no clearing pass.
// ----------------------------------------------------------------------------
// Printable character histogram, top level
// Counts printable bytes per session and keeps running per-character totals.
// ----------------------------------------------------------------------------
module printable_char_histogram_top
    import phc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Input item channel
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [1:0]           i_command,
    input  logic [BYTE_W-1:0]    i_data_byte,
    input  logic [LEN_W-1:0]     i_expected_length,
    input  logic [CHAR_W-1:0]    i_bin_index,
    // Result channel
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [1:0]           o_result_kind,
    output logic [VALUE_W-1:0]   o_value,
    // Configuration write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CHAR_W-1:0]    i_cfg_data
);

    // S_BUMP writes back an incremented session bin. S_READ captures a total.
    // S_WALK adds every session bin into its total. S_EMIT waits for the
    // output register to accept the pending result.
    typedef enum logic [2:0] {
        S_IDLE,
        S_BUMP,
        S_READ,
        S_WALK,
        S_EMIT
    } t_state;

    t_state               r_state, n_state;
    logic                 r_active, n_active;
    t_cnt                 r_count, n_count;
    logic [LEN_W-1:0]     r_remain, n_remain;
    logic [CHAR_W-1:0]    r_low, n_low;
    logic [CHAR_W-1:0]    r_high, n_high;
    logic [BIN_COUNT-1:0] r_ses_vld, n_ses_vld;
    logic [BIN_COUNT-1:0] r_tot_vld, n_tot_vld;
    logic [BIN_BITS-1:0]  r_walk, n_walk;
    logic                 r_wb_vld, n_wb_vld;
    logic [BIN_BITS-1:0]  r_wb_addr, n_wb_addr;
    logic [BIN_BITS-1:0]  r_bump_addr, n_bump_addr;
    logic                 r_ses_ok, n_ses_ok;
    logic                 r_tot_ok, n_tot_ok;
    t_result              r_pend, n_pend;

    logic                 accept;
    logic                 in_range;
    logic                 out_free;
    logic                 out_load;
    logic [BIN_BITS-1:0]  ses_raddr, tot_raddr;
    t_cnt                 ses_rd, tot_rd, ses_val, tot_val;
    logic                 ses_we;
    t_cnt                 ses_wdata, tot_wdata;

    assign accept      = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    assign in_range = ({1'b0, i_data_byte} >= {2'b00, r_low})
                   && ({1'b0, i_data_byte} <= {2'b00, r_high});

    // During the walk both RAMs are read at the walk pointer; otherwise the
    // session RAM is addressed by the incoming byte and the total RAM by the
    // requested bin.
    assign ses_raddr = (r_state == S_WALK) ? r_walk : BIN_BITS'(i_data_byte);
    assign tot_raddr = (r_state == S_WALK) ? r_walk : BIN_BITS'(i_bin_index);

    // An entry whose valid flag was clear when it was read counts as zero.
    assign ses_val = r_ses_ok ? ses_rd : '0;
    assign tot_val = r_tot_ok ? tot_rd : '0;

    assign ses_we    = (r_state == S_BUMP);
    assign ses_wdata = ses_val + t_cnt'(1);
    assign tot_wdata = tot_val + ses_val;

    assign out_load = (r_state == S_EMIT);

    phc_ram #(
        .DEPTH (BIN_COUNT),
        .WIDTH (COUNTER_BITS)
    ) u_ses_ram (
        .i_clk   (i_clk),
        .i_we    (ses_we),
        .i_waddr (r_bump_addr),
        .i_wdata (ses_wdata),
        .i_raddr (ses_raddr),
        .o_rdata (ses_rd)
    );

    phc_ram #(
        .DEPTH (BIN_COUNT),
        .WIDTH (COUNTER_BITS)
    ) u_tot_ram (
        .i_clk   (i_clk),
        .i_we    (r_wb_vld),
        .i_waddr (r_wb_addr),
        .i_wdata (tot_wdata),
        .i_raddr (tot_raddr),
        .o_rdata (tot_rd)
    );

    phc_out_reg u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (out_load),
        .i_res         (r_pend),
        .o_free        (out_free),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_result_kind (o_result_kind),
        .o_value       (o_value)
    );

    always_comb begin
        n_state     = r_state;
        n_active    = r_active;
        n_count     = r_count;
        n_remain    = r_remain;
        n_low       = r_low;
        n_high      = r_high;
        n_ses_vld   = r_ses_vld;
        n_tot_vld   = r_tot_vld;
        n_walk      = r_walk;
        n_wb_vld    = (r_state == S_WALK);
        n_wb_addr   = r_walk;
        n_bump_addr = r_bump_addr;
        n_ses_ok    = r_ses_vld[ses_raddr];
        n_tot_ok    = r_tot_vld[tot_raddr];
        n_pend      = r_pend;

        // The user must send configuration writes only while the block is idle; the block itself does not enforce it.
        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_LOW_CHAR:  n_low  = i_cfg_data;
                CFG_HIGH_CHAR: n_high = i_cfg_data;
                default: ;
            endcase
        end

        // A total write-back marks its entry as holding real data.
        if (r_wb_vld) begin
            n_tot_vld[r_wb_addr] = 1'b1;
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (t_cmd'(i_command))
                        CMD_START: begin
                            // Opening a session drops any open one silently.
                            n_ses_vld = '0;
                            n_count   = '0;
                            n_remain  = i_expected_length;
                            if (i_expected_length == '0) begin
                                // Empty session: all bins are zero, the totals
                                // stay as they are, so no walk is needed.
                                n_active = 1'b0;
                                n_pend   = '{kind: KIND_DONE, value: '0};
                                n_state  = S_EMIT;
                            end else begin
                                n_active = 1'b1;
                            end
                        end
                        CMD_DATA: begin
                            if (r_active) begin
                                n_remain = r_remain - LEN_W'(1);
                                if (in_range) begin
                                    n_count = r_count + t_cnt'(1);
                                end
                                if (in_range && (int'(i_data_byte) < BIN_COUNT)) begin
                                    n_bump_addr = BIN_BITS'(i_data_byte);
                                    n_state     = S_BUMP;
                                end else if (n_remain == '0) begin
                                    n_active = 1'b0;
                                    n_walk   = '0;
                                    n_pend   = '{kind: KIND_DONE,
                                                 value: VALUE_W'(n_count)};
                                    n_state  = S_WALK;
                                end
                            end
                        end
                        CMD_ABORT: begin
                            if (r_active) begin
                                n_active = 1'b0;
                                n_pend   = '{kind: KIND_ABORTED,
                                             value: VALUE_W'(r_count)};
                                n_state  = S_EMIT;
                            end
                        end
                        CMD_READ: begin
                            if (int'(i_bin_index) < BIN_COUNT) begin
                                n_state = S_READ;
                            end else begin
                                n_pend  = '{kind: KIND_READ, value: '0};
                                n_state = S_EMIT;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_BUMP: begin
                n_ses_vld[r_bump_addr] = 1'b1;
                if (r_remain == '0) begin
                    n_active = 1'b0;
                    n_walk   = '0;
                    n_pend   = '{kind: KIND_DONE, value: VALUE_W'(r_count)};
                    n_state  = S_WALK;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_READ: begin
                n_pend  = '{kind: KIND_READ, value: VALUE_W'(tot_val)};
                n_state = S_EMIT;
            end
            S_WALK: begin
                // The last write-back lands during S_EMIT, before any new item.
                n_walk = r_walk + BIN_BITS'(1);
                if (r_walk == BIN_BITS'(BIN_COUNT - 1)) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_walk      <= n_walk;
        r_wb_addr   <= n_wb_addr;
        r_bump_addr <= n_bump_addr;
        r_ses_ok    <= n_ses_ok;
        r_tot_ok    <= n_tot_ok;
        r_pend      <= n_pend;
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_active  <= 1'b0;
            r_low     <= LOW_CHAR_RST;
            r_high    <= HIGH_CHAR_RST;
            r_ses_vld <= '0;
            r_tot_vld <= '0;
            r_wb_vld  <= 1'b0;
            r_count   <= '0;
            r_remain  <= '0;
        end else begin
            r_state   <= n_state;
            r_active  <= n_active;
            r_low     <= n_low;
            r_high    <= n_high;
            r_ses_vld <= n_ses_vld;
            r_tot_vld <= n_tot_vld;
            r_wb_vld  <= n_wb_vld;
            r_count   <= n_count;
            r_remain  <= n_remain;
        end
    end

endmodule

// ===== src/phc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Printable character histogram port checker
// Watches the top-level ports over time and reports violations.
// ----------------------------------------------------------------------------
module phc_checker
    import phc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 o_in_stall,
    input  logic [1:0]           i_command,
    input  logic                 o_out_valid,
    input  logic                 i_out_stall,
    input  logic [1:0]           o_result_kind,
    input  logic [VALUE_W-1:0]   o_value
);

    // A stalled result beat stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_result_kind) && $stable(o_value))
        else $error("result beat changed while stalled");

    // A read beat always keeps the block busy for the RAM access.
    a_read_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_command == CMD_READ) |=> o_in_stall)
        else $error("read beat did not occupy the block");

    // A new result only appears when the block was busy in the previous cycle.
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result beat appeared without work behind it");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind printable_char_histogram_top phc_checker u_phc_checker (.*);

// ===== sim/tb_printable_char_histogram_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Printable character histogram testbench
// Drives command beats through the block and checks every result beat against
// a cycle-free model of the session and total histograms kept alongside it.
// The run walks through several limit settings, including the extremes, and
// ends with a stretch at full rate on both sides.
// ----------------------------------------------------------------------------
module tb_printable_char_histogram_top;
    import phc_pkg::*;

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 4;
    // A session close walks every bin before the block is idle again.
    localparam int SETTLE_CYCLES = 2 * BIN_COUNT + 16;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int REPORT_LIMIT  = 10;

    // One command beat as presented on the input channel.
    typedef struct {
        t_cmd                cmd;
        logic [BYTE_W-1:0]   octet;
        logic [LEN_W-1:0]    len;
        logic [CHAR_W-1:0]   idx;
    } t_beat;

    // ------------------------------------------------------------------------
    // Block ports. Every input starts at a known value.
    // ------------------------------------------------------------------------
    logic                  i_clk;
    logic                  i_rst_n           = 1'b0;
    logic                  i_in_valid        = 1'b0;
    logic                  o_in_stall;
    logic [1:0]            i_command         = CMD_READ;
    logic [BYTE_W-1:0]     i_data_byte       = '0;
    logic [LEN_W-1:0]      i_expected_length = '0;
    logic [CHAR_W-1:0]     i_bin_index       = '0;
    logic                  o_out_valid;
    logic                  i_out_stall       = 1'b0;
    logic [1:0]            o_result_kind;
    logic [VALUE_W-1:0]    o_value;
    logic                  i_cfg_valid       = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index       = CFG_LOW_CHAR;
    logic [CHAR_W-1:0]     i_cfg_data        = '0;

    printable_char_histogram_top dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_command         (i_command),
        .i_data_byte       (i_data_byte),
        .i_expected_length (i_expected_length),
        .i_bin_index       (i_bin_index),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_result_kind     (o_result_kind),
        .o_value           (o_value),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #(CLK_HALF);
        i_clk = 1'b0;
        #(CLK_HALF);
    end

    // ------------------------------------------------------------------------
    // Histogram model state. It is touched only at accepted beats and at
    // limit writes, and limit writes happen only while the block is idle.
    // ------------------------------------------------------------------------
    t_cnt               session_hist [BIN_COUNT];
    t_cnt               total_hist   [BIN_COUNT];
    t_cnt               session_count;
    logic [LEN_W-1:0]   bytes_left;
    logic               session_open;
    logic [CHAR_W-1:0]  lo_char;
    logic [CHAR_W-1:0]  hi_char;

    t_beat    pending_beats[$];      // beats waiting for the driver
    t_result  predicted_reports[$];  // results the block still owes us
    int       beats_queued   = 0;
    int       beats_accepted = 0;
    int       err_count      = 0;
    int       cycle_count    = 0;
    int       gap_percent    = 0;    // chance that a beat or result slot idles
    int       gap_left       = 0;
    int       stall_left     = 0;
    t_beat    cur_beat;
    t_result  want_report;

    // A close folds the session bins into the totals and hands back the count.
    function automatic t_cnt commit_session();
        for (int i = 0; i < BIN_COUNT; i++) begin
            total_hist[i] = total_hist[i] + session_hist[i];
        end
        session_open = 1'b0;
        return session_count;
    endfunction

    // Applies one accepted beat and queues the result it causes, if any.
    function automatic void histogram_step(input t_beat b);
        t_result r;
        logic    has_result;
        has_result = 1'b0;
        r.kind     = KIND_DONE;
        r.value    = '0;
        case (b.cmd)
            CMD_START: begin
                // A start always wipes the session, even over an open one.
                foreach (session_hist[i]) session_hist[i] = '0;
                session_count = '0;
                bytes_left    = b.len;
                session_open  = 1'b1;
                if (bytes_left == '0) begin
                    r.kind     = KIND_DONE;
                    r.value    = commit_session();
                    has_result = 1'b1;
                end
            end
            CMD_DATA: begin
                if (session_open) begin
                    if (b.octet >= {1'b0, lo_char} && b.octet <= {1'b0, hi_char}) begin
                        session_count = session_count + 1'b1;
                        if (b.octet < BIN_COUNT) begin
                            session_hist[b.octet] = session_hist[b.octet] + 1'b1;
                        end
                    end
                    // Uncounted bytes still use up the expected length.
                    bytes_left = bytes_left - 1'b1;
                    if (bytes_left == '0) begin
                        r.kind     = KIND_DONE;
                        r.value    = commit_session();
                        has_result = 1'b1;
                    end
                end
            end
            CMD_ABORT: begin
                if (session_open) begin
                    session_open = 1'b0;
                    r.kind       = KIND_ABORTED;
                    r.value      = session_count;
                    has_result   = 1'b1;
                end
            end
            default: begin
                r.kind     = KIND_READ;
                r.value    = (b.idx < BIN_COUNT) ? total_hist[b.idx] : '0;
                has_result = 1'b1;
            end
        endcase
        if (has_result) predicted_reports.push_back(r);
    endfunction

    function automatic void report_failure(input string msg);
        err_count++;
        if (err_count <= REPORT_LIMIT) $display("ERROR @%0t: %s", $realtime, msg);
    endfunction

    // Fields that the command does not use get random values so that their
    // bits move all the same.
    task automatic push_beat(input t_cmd c, input int octet, input int len, input int idx);
        t_beat b;
        b.cmd   = c;
        b.octet = (c == CMD_DATA)  ? octet[BYTE_W-1:0] : BYTE_W'($urandom_range(0, 255));
        b.len   = (c == CMD_START) ? len[LEN_W-1:0]    : LEN_W'($urandom_range(0, 65535));
        b.idx   = (c == CMD_READ)  ? idx[CHAR_W-1:0]   : CHAR_W'($urandom_range(0, 127));
        pending_beats.push_back(b);
        beats_queued++;
    endtask

    // Byte picker: often a small alphabet so that the totals build up, plus
    // values around the current limits and the full byte range.
    function automatic int pick_char();
        case ($urandom_range(0, 4))
            0:       return $urandom_range(0, 255);
            1:       return $urandom_range(0, 127);
            2:       return ($urandom_range(0, 1) ? int'(lo_char) : int'(hi_char))
                            + $urandom_range(0, 2) - 1;
            default: return 97 + $urandom_range(0, 7);
        endcase
    endfunction

    function automatic int pick_index();
        return $urandom_range(0, 1) ? 97 + $urandom_range(0, 7) : $urandom_range(0, 127);
    endfunction

    // Random traffic. Most of it is complete sessions with random content;
    // the rest is cut-short sessions, stray reads and beats the block drops.
    task automatic queue_random_sessions(input int n);
        int made;
        int len;
        int cut;
        made = 0;
        while (made < n) begin
            case ($urandom_range(0, 99)) inside
                [0:64]: begin
                    len = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 40)
                                                      : $urandom_range(0, 10);
                    cut = (len > 0 && $urandom_range(0, 7) == 0) ? $urandom_range(0, len - 1)
                                                                 : -1;
                    push_beat(CMD_START, 0, len, 0);
                    made++;
                    for (int k = 0; k < len; k++) begin
                        if (k == cut) begin
                            push_beat(CMD_ABORT, 0, 0, 0);
                            made++;
                            break;
                        end
                        if ($urandom_range(0, 9) == 0) begin
                            push_beat(CMD_READ, 0, 0, pick_index());
                            made++;
                        end
                        push_beat(CMD_DATA, pick_char(), 0, 0);
                        made++;
                    end
                end
                [65:77]: begin
                    push_beat(CMD_READ, 0, 0, pick_index());
                    made++;
                end
                [78:85]: begin
                    // A long session that is aborted or left for the next start.
                    push_beat(CMD_START, 0, $urandom_range(0, 65535), 0);
                    made++;
                    repeat ($urandom_range(0, 4)) begin
                        push_beat(CMD_DATA, pick_char(), 0, 0);
                        made++;
                    end
                    if ($urandom_range(0, 1)) begin
                        push_beat(CMD_ABORT, 0, 0, 0);
                        made++;
                    end
                end
                [86:92]: begin
                    push_beat(CMD_DATA, pick_char(), 0, 0);
                    made++;
                end
                default: begin
                    push_beat(CMD_ABORT, 0, 0, 0);
                    made++;
                end
            endcase
        end
    endtask

    // Limit writes go through their own channel while the block is idle.
    task automatic write_limit(input logic [CFG_IDX_W-1:0] idx, input logic [CHAR_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_LOW_CHAR) lo_char = val;
        else hi_char = val;
    endtask

    // Waits on the falling edge, when all rising-edge work has settled, until
    // every beat is in and every result is out, then lets trailing bin walks
    // finish.
    task automatic wait_drained();
        do @(negedge i_clk);
        while (beats_accepted != beats_queued || predicted_reports.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Driver: holds a beat until it is taken, and idles in random bursts.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                histogram_step(cur_beat);
                beats_accepted++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (gap_left > 0) begin
                    gap_left   <= gap_left - 1;
                    i_in_valid <= 1'b0;
                end else if (pending_beats.size() > 0) begin
                    if (gap_percent != 0 && $urandom_range(0, 99) < gap_percent) begin
                        // This slot idles and a random idle burst is drawn into gap_left.
                        gap_left   <= $urandom_range(0, 5);
                        i_in_valid <= 1'b0;
                    end else begin
                        cur_beat          <= pending_beats[0];
                        i_command         <= pending_beats[0].cmd;
                        i_data_byte       <= pending_beats[0].octet;
                        i_expected_length <= pending_beats[0].len;
                        i_bin_index       <= pending_beats[0].idx;
                        i_in_valid        <= 1'b1;
                        void'(pending_beats.pop_front());
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: checks each accepted result beat against the oldest prediction
    // and stalls the result channel in random bursts.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (predicted_reports.size() == 0) begin
                    report_failure($sformatf("unexpected result: kind %0d value %0d",
                                             o_result_kind, o_value));
                end else begin
                    want_report = predicted_reports.pop_front();
                    if (o_result_kind !== want_report.kind) begin
                        report_failure($sformatf("result kind: expected %0d, got %0d",
                                                 want_report.kind, o_result_kind));
                    end
                    if (o_value !== want_report.value) begin
                        report_failure($sformatf("value (kind %0d): expected %0d, got %0d",
                                                 want_report.kind, want_report.value, o_value));
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left  <= stall_left - 1;
                i_out_stall <= 1'b1;
            end else if (gap_percent != 0 && $urandom_range(0, 99) < gap_percent) begin
                stall_left  <= $urandom_range(0, 5);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // A hung handshake ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sequence of phases. Each phase after the first sets the limits, queues its beats and
    // waits for the block to drain before the next one.
    // ------------------------------------------------------------------------
    initial begin
        foreach (session_hist[i]) begin
            session_hist[i] = '0;
            total_hist[i]   = '0;
        end
        session_count = '0;
        bytes_left    = '0;
        session_open  = 1'b0;
        lo_char       = LOW_CHAR_RST;
        hi_char       = HIGH_CHAR_RST;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed beats at the reset limits of space through tilde.
        gap_percent = 25;
        push_beat(CMD_READ,  0, 0, 0);        // a total before any session is zero
        push_beat(CMD_DATA,  65, 0, 0);       // data with no session is dropped
        push_beat(CMD_ABORT, 0, 0, 0);        // so is an abort
        push_beat(CMD_START, 0, 0, 0);        // zero length closes at once with zero
        push_beat(CMD_START, 0, 5, 0);
        push_beat(CMD_DATA,  32, 0, 0);       // both limits are inclusive
        push_beat(CMD_DATA,  126, 0, 0);
        push_beat(CMD_DATA,  31, 0, 0);       // just outside each limit
        push_beat(CMD_DATA,  127, 0, 0);
        push_beat(CMD_DATA,  255, 0, 0);      // top bit set: never counted
        push_beat(CMD_READ,  0, 0, 32);
        push_beat(CMD_READ,  0, 0, 126);
        push_beat(CMD_READ,  0, 0, 127);
        push_beat(CMD_START, 0, 3, 0);
        push_beat(CMD_DATA,  65, 0, 0);
        push_beat(CMD_START, 0, 2, 0);        // restart drops the open session quietly
        push_beat(CMD_DATA,  66, 0, 0);
        push_beat(CMD_DATA,  128, 0, 0);
        push_beat(CMD_READ,  0, 0, 65);       // the dropped 'A' never reached the totals
        push_beat(CMD_READ,  0, 0, 66);
        push_beat(CMD_START, 0, 16'h5AA5, 0);
        push_beat(CMD_DATA,  120, 0, 0);
        push_beat(CMD_ABORT, 0, 0, 0);        // abort reports the count but commits nothing
        push_beat(CMD_READ,  0, 0, 120);
        wait_drained();

        // Widest window: every 7-bit value counts, zero included.
        write_limit(CFG_LOW_CHAR, 7'd0);
        write_limit(CFG_HIGH_CHAR, 7'd127);
        gap_percent = 30;
        queue_random_sessions(150);
        wait_drained();

        // Inverted window: nothing counts.
        write_limit(CFG_LOW_CHAR, 7'd127);
        write_limit(CFG_HIGH_CHAR, 7'd0);
        queue_random_sessions(100);
        wait_drained();

        // Upper-case letters only, at full rate on both sides.
        write_limit(CFG_LOW_CHAR, 7'd65);
        write_limit(CFG_HIGH_CHAR, 7'd90);
        gap_percent = 0;
        queue_random_sessions(150);
        wait_drained();

        // Random window, heavy idling.
        write_limit(CFG_LOW_CHAR, CHAR_W'($urandom_range(0, 127)));
        write_limit(CFG_HIGH_CHAR, CHAR_W'($urandom_range(0, 127)));
        gap_percent = 50;
        queue_random_sessions(150);
        wait_drained();

        // Back to the reset window.
        write_limit(CFG_LOW_CHAR, LOW_CHAR_RST);
        write_limit(CFG_HIGH_CHAR, HIGH_CHAR_RST);
        gap_percent = 20;
        queue_random_sessions(150);
        wait_drained();

        // Closing stretch with no idling at all.
        gap_percent = 0;
        write_limit(CFG_LOW_CHAR, 7'd48);
        write_limit(CFG_HIGH_CHAR, 7'd122);
        queue_random_sessions(150);
        wait_drained();

        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
